// File: hdl/lgm_pkg.sv
package lgm_pkg;

  localparam int SampleW  = 24;
  localparam int OffsetW  = 18;
  localparam int WeightW  = 16;
  localparam int GainW    = 16;
  localparam int ChanW    = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  // exponent split: integer part n, fraction f
  localparam int ExpFrac  = 16;
  localparam int ExpIntW  = 6;
  localparam int ProdFrac = 10;  // fraction bits dropped from log_gain * weight
  localparam int RomFrac  = 30;
  localparam int RomW     = 32;
  localparam int MantW    = 31;
  localparam int SumW     = SampleW + 1;
  localparam int ProdW    = SumW + MantW + 1;
  localparam int RndW     = ProdW + 1;
  localparam int ShiftW   = 6;
  localparam int ResW     = 45;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [OffsetW-1:0] OffsetRst = OffsetW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_WEIGHT   = 3'd0,
    CFG_BASE_RED      = 3'd1,
    CFG_BASE_GREEN    = 3'd2,
    CFG_BASE_BLUE     = 3'd3,
    CFG_ALT_RED       = 3'd4,
    CFG_ALT_GREEN     = 3'd5,
    CFG_ALT_BLUE      = 3'd6
  } cfg_idx_e;

  // payload that rides along the pipeline next to the valid bits
  typedef struct packed {
    logic                       bypass;
    logic [SampleW-1:0]         bs;
    logic signed [SumW-1:0]     sum;
    logic signed [OffsetW-1:0]  alt;
    logic signed [ExpIntW-1:0]  n;
    logic [ExpFrac-1:0]         f;
  } carry_t;

  typedef logic [ExpFrac:1][RomW-1:0] exp_rom_t;

  function automatic logic [RomW-1:0] isqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem = x;
    res = '0;
    for (int i = 0; i < 32; i++) begin
      bit_v = 64'd1 << (62 - 2 * i);
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
    end
    return res[RomW-1:0];
  endfunction

  // c[k] = 2^(2^-k) in Q2.30, each entry the square root of the one before
  function automatic exp_rom_t exp_rom_gen();
    exp_rom_t    rom;
    logic [63:0] c;
    c = 64'd1 << (RomFrac + 1);
    for (int k = 1; k <= ExpFrac; k++) begin
      c = {32'd0, isqrt(c << RomFrac)};
      rom[k] = c[RomW-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t ExpRom = exp_rom_gen();

endpackage

// File: hdl/log_gain_map_pixel_apply.sv
// Throughput: one item per cycle when the output does not stall; the 16 exp2 multiply
// stages, the sample multiply, the rounding shift and the offset/clip stage each hold
// one register slot. Empty slots collapse, so a stalled output still lets items enter
// until the pipe is full. Reset clears all valid bits; gain_weight resets to 0 and all
// offsets to 1024.
module log_gain_map_pixel_apply (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [lgm_pkg::SampleW-1:0]    base_sample_i,
  input  logic [lgm_pkg::ChanW-1:0]             channel_index_i,
  input  logic                                  is_alpha_i,
  input  logic signed [lgm_pkg::GainW-1:0]      log_gain_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [lgm_pkg::SampleW-1:0]    out_sample_o,
  output logic                                  saturated_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lgm_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [lgm_pkg::CfgDataW-1:0]          cfg_data_i
);

  localparam int StA   = 0;
  localparam int StB   = 1;
  localparam int StE0  = 2;
  localparam int StP   = StE0 + lgm_pkg::ExpFrac;
  localparam int StR   = StP + 1;
  localparam int StO   = StR + 1;
  localparam int NStg  = StO + 1;

  // configuration registers
  logic signed [lgm_pkg::WeightW-1:0] weight_q;
  logic signed [lgm_pkg::OffsetW-1:0] base_off_q [3];
  logic signed [lgm_pkg::OffsetW-1:0] alt_off_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
      for (int i = 0; i < 3; i++) begin
        base_off_q[i] <= lgm_pkg::OffsetRst;
        alt_off_q[i]  <= lgm_pkg::OffsetRst;
      end
    end else if (cfg_valid_i) begin
      case (lgm_pkg::cfg_idx_e'(cfg_index_i))
        lgm_pkg::CFG_GAIN_WEIGHT: weight_q     <= cfg_data_i[lgm_pkg::WeightW-1:0];
        lgm_pkg::CFG_BASE_RED:    base_off_q[0] <= cfg_data_i;
        lgm_pkg::CFG_BASE_GREEN:  base_off_q[1] <= cfg_data_i;
        lgm_pkg::CFG_BASE_BLUE:   base_off_q[2] <= cfg_data_i;
        lgm_pkg::CFG_ALT_RED:     alt_off_q[0]  <= cfg_data_i;
        lgm_pkg::CFG_ALT_GREEN:   alt_off_q[1]  <= cfg_data_i;
        lgm_pkg::CFG_ALT_BLUE:    alt_off_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control: a slot loads when it is empty or its contents move on
  logic [NStg-1:0] valid_q;
  logic [NStg-1:0] valid_in;
  logic [NStg-1:0] adv;

  assign valid_in = {valid_q[NStg-2:0], in_valid_i};

  always_comb begin
    adv[NStg-1] = !valid_q[NStg-1] || !out_stall_i;
    for (int s = NStg - 2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign in_stall_o = !adv[StA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NStg; s++) begin
        if (adv[s]) begin
          valid_q[s] <= valid_in[s];
        end
      end
    end
  end

  // carried payload
  lgm_pkg::carry_t carry_q [NStg];
  lgm_pkg::carry_t carry_d [NStg];

  logic [1:0]                              ch_sel;
  logic signed [2*lgm_pkg::GainW-1:0]      p_q;
  logic signed [2*lgm_pkg::GainW:0]        p_rnd;
  logic signed [2*lgm_pkg::GainW-lgm_pkg::ProdFrac-1:0] e_w;

  // channels above blue use the blue offsets
  assign ch_sel = (channel_index_i == 2'd3) ? 2'd2 : channel_index_i;

  assign p_rnd = (2 * lgm_pkg::GainW + 1)'(p_q)
               + (2 * lgm_pkg::GainW + 1)'(1 << (lgm_pkg::ProdFrac - 1));
  assign e_w   = p_rnd[2*lgm_pkg::GainW-1:lgm_pkg::ProdFrac];

  always_comb begin
    carry_d[StA].bypass = is_alpha_i || (weight_q == '0);
    carry_d[StA].bs     = base_sample_i;
    carry_d[StA].sum    = lgm_pkg::SumW'(base_sample_i) + lgm_pkg::SumW'(base_off_q[ch_sel]);
    carry_d[StA].alt    = alt_off_q[ch_sel];
    carry_d[StA].n      = '0;
    carry_d[StA].f      = '0;
    for (int s = 1; s < NStg; s++) begin
      carry_d[s] = carry_q[s-1];
    end
    // split the rounded exponent into integer and fraction
    carry_d[StB].n = e_w[lgm_pkg::ExpFrac +: lgm_pkg::ExpIntW];
    carry_d[StB].f = e_w[lgm_pkg::ExpFrac-1:0];
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NStg; s++) begin
      if (adv[s]) begin
        carry_q[s] <= carry_d[s];
      end
    end
    if (adv[StA]) begin
      p_q <= log_gain_i * weight_q;
    end
  end

  // exp2 of the fraction: one ROM factor per bit, one multiply per stage
  logic [lgm_pkg::MantW-1:0] m_q [1:lgm_pkg::ExpFrac];

  for (genvar k = 1; k <= lgm_pkg::ExpFrac; k++) begin : g_exp
    localparam int St = StE0 + k - 1;
    logic [lgm_pkg::MantW-1:0]              m_in;
    logic [lgm_pkg::MantW+lgm_pkg::RomW-1:0] mc;
    logic [lgm_pkg::MantW+lgm_pkg::RomW-1:0] mr;
    logic [lgm_pkg::MantW-1:0]              m_d;

    if (k == 1) begin : g_first
      assign m_in = lgm_pkg::MantW'(1) << lgm_pkg::RomFrac;
    end else begin : g_next
      assign m_in = m_q[k-1];
    end

    assign mc  = (lgm_pkg::MantW + lgm_pkg::RomW)'(m_in)
               * (lgm_pkg::MantW + lgm_pkg::RomW)'(lgm_pkg::ExpRom[k]);
    assign mr  = mc + ((lgm_pkg::MantW + lgm_pkg::RomW)'(1) << (lgm_pkg::RomFrac - 1));
    assign m_d = carry_q[St-1].f[lgm_pkg::ExpFrac-k] ? mr[lgm_pkg::RomFrac +: lgm_pkg::MantW]
                                                     : m_in;

    always_ff @(posedge clk_i) begin
      if (adv[St]) begin
        m_q[k] <= m_d;
      end
    end
  end

  // sample plus base offset times mantissa, then round and shift by 30 - n
  logic signed [lgm_pkg::ProdW-1:0]  prod_q;
  logic [lgm_pkg::ShiftW-1:0]        h_q;
  logic [lgm_pkg::ShiftW-1:0]        h_d;
  logic signed [lgm_pkg::RndW-1:0]   rnd;
  logic signed [lgm_pkg::RndW-1:0]   shifted;
  logic signed [lgm_pkg::ResW-1:0]   r_q;

  assign h_d = lgm_pkg::ShiftW'((lgm_pkg::ShiftW + 1)'(lgm_pkg::RomFrac)
             - (lgm_pkg::ShiftW + 1)'($signed(carry_q[StP-1].n)));

  assign rnd     = lgm_pkg::RndW'(prod_q) + (lgm_pkg::RndW'(1) <<< (h_q - 1'b1));
  assign shifted = rnd >>> h_q;

  always_ff @(posedge clk_i) begin
    if (adv[StP]) begin
      prod_q <= $signed(carry_q[StP-1].sum) * $signed({1'b0, m_q[lgm_pkg::ExpFrac]});
      h_q    <= h_d;
    end
    if (adv[StR]) begin
      r_q <= shifted[lgm_pkg::ResW-1:0];
    end
  end

  // subtract alternate offset, clip to the sample range; bypass items keep the base sample
  logic signed [lgm_pkg::ResW:0]      diff;
  logic signed [lgm_pkg::SampleW-1:0] out_sample_q;
  logic                               sat_q;

  assign diff = (lgm_pkg::ResW + 1)'(r_q) - (lgm_pkg::ResW + 1)'($signed(carry_q[StR].alt));

  always_ff @(posedge clk_i) begin
    if (adv[StO]) begin
      if (carry_q[StR].bypass) begin
        out_sample_q <= carry_q[StR].bs;
        sat_q        <= 1'b0;
      end else if (diff > (lgm_pkg::ResW + 1)'(lgm_pkg::SampleMax)) begin
        out_sample_q <= lgm_pkg::SampleMax;
        sat_q        <= 1'b1;
      end else if (diff < (lgm_pkg::ResW + 1)'(lgm_pkg::SampleMin)) begin
        out_sample_q <= lgm_pkg::SampleMin;
        sat_q        <= 1'b1;
      end else begin
        out_sample_q <= diff[lgm_pkg::SampleW-1:0];
        sat_q        <= 1'b0;
      end
    end
  end

  assign out_valid_o  = valid_q[StO];
  assign out_sample_o = out_sample_q;
  assign saturated_o  = sat_q;

endmodule

// File: hdl/lgm_checker.sv
module lgm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [lgm_pkg::SampleW-1:0]  out_sample_o,
  input logic                                saturated_o
);

  // the input only backs up when the whole pipe is full behind a stalled output
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output side can move");

  // a waiting input item is taken as soon as the output transfers
  a_take_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o && !out_stall_i) |-> ##0 !in_stall_o || !out_valid_o)
    else $error("output transferred but input still stalled");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (out_sample_o == lgm_pkg::SampleMax || out_sample_o == lgm_pkg::SampleMin))
    else $error("saturation flag without a clipped sample");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_sample_o) && $stable(saturated_o)))
    else $error("stalled result changed");

endmodule

bind log_gain_map_pixel_apply lgm_checker u_lgm_checker (.*);
